>>> rtl/core/spp_pkg.sv
// Shared types and constants of the stepper pulse positioner.
package spp_pkg;

	// Debounce and speed limits
	localparam int unsigned END_DEBOUNCE    = 8;
	localparam int unsigned START_SPEED_CAP = 200;
	localparam int unsigned DEB_W           = $clog2(END_DEBOUNCE + 1);

	// Field widths
	localparam int unsigned POS_W   = 32;
	localparam int unsigned SPEED_W = 16;
	localparam int unsigned STEPS_W = 24;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = 32;

	// Reset values
	localparam logic [POS_W-1:0]   POS_RESET           = 32'h7FFF_FFFF;
	localparam logic [LEVEL_W-1:0] OPTIC_THRESH_RESET  = 16'd2048;
	localparam logic [POS_W-1:0]   PULL_LIMIT_RESET    = 32'd2147485648;
	localparam logic [SPEED_W-1:0] SPEED_CAP           = SPEED_W'(START_SPEED_CAP);
	localparam logic [DEB_W-1:0]   DEB_LIMIT           = DEB_W'(END_DEBOUNCE);

	// Item kind
	typedef enum logic {
		ITEM_START = 1'b0,
		ITEM_PULSE = 1'b1
	} item_kind_t;

	// Stop modes
	typedef enum logic [2:0] {
		SM_END        = 3'd0,
		SM_OPT1_CHECK = 3'd1,
		SM_OPT0_CHECK = 3'd2,
		SM_OPT0_SEEK  = 3'd3,
		SM_OPT1_SEEK  = 3'd4,
		SM_FREE       = 3'd5,
		SM_STOP       = 3'd6,
		SM_NONE       = 3'd7
	} stop_mode_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_OPTIC_THRESHOLD = 1'b0,
		REG_PULL_LIMIT      = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                 mode;
		logic [SPEED_W-1:0]   target_speed;
		logic [STEPS_W-1:0]   step_count;
		logic                 push_direction;
		logic [2:0]           stop_mode;
		logic                 end_switch;
		logic [LEVEL_W-1:0]   optic0_level;
		logic [LEVEL_W-1:0]   optic1_level;
	} in_item_t;

	typedef struct packed {
		logic                 moving;
		logic                 stop_now;
		logic [POS_W-1:0]     position;
		logic [SPEED_W-1:0]   current_speed;
		logic                 optic_ok;
		logic                 end_hit;
	} out_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0]  index;
		logic [CFG_DATA_W-1:0] data;
	} cfg_item_t;

endpackage

>>> rtl/core/spp_stream_if.sv
// Valid/ready channel carrying one payload per transaction.
interface spp_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

>>> rtl/core/stepper_pulse_positioner.sv
// Stepper pulse positioner: position tracking, stop rules and speed ramp for one motor.
//
// One item is taken per clock cycle while the output is not stalled. An accepted item
// lands in an input register; once the output register is empty or being taken, the
// move state is updated and the result is written to the output register, which holds
// it until it is taken. The update of the move state sets the rate: each item sees the
// state left by the one before it. The output register lets a new item enter while a
// finished result still waits; the input side stalls only while the output is full
// and not taken. Configuration writes are taken in every cycle and should be issued
// while no item is in flight.
module stepper_pulse_positioner
	import spp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	spp_stream_if.sink   in_item,
	spp_stream_if.source out_item,
	spp_stream_if.sink   cfg
);

	// Configuration registers
	logic [LEVEL_W-1:0] optic_thresh_q;
	logic [POS_W-1:0]   pull_limit_q;

	// Move state
	logic [POS_W-1:0]   pos_q;
	logic [STEPS_W-1:0] steps_q;
	logic [DEB_W-1:0]   deb_q;
	logic [SPEED_W-1:0] speed_q;
	logic [SPEED_W-1:0] goal_q;
	logic               push_q;
	stop_mode_t         lmode_q;
	logic               optic_q;
	logic               run_q;

	// Pipeline registers
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_q;
	logic      out_valid_q;

	// Next-state logic
	logic [POS_W-1:0]   pos_n;
	logic [STEPS_W-1:0] steps_n;
	logic [DEB_W-1:0]   deb_n;
	logic [SPEED_W-1:0] speed_n;
	logic [SPEED_W-1:0] goal_n;
	logic               push_n;
	stop_mode_t         lmode_n;
	logic               optic_n;
	logic               run_n;
	logic               stop;
	logic               fired;

	logic [POS_W-1:0]   pos_step;
	logic [LEVEL_W-1:0] opt_sel;
	logic               opt_seen;
	logic               hit;
	logic [DEB_W-1:0]   deb_bound;
	logic [DEB_W-1:0]   deb_max;
	logic               fire_cand;
	logic [DEB_W-1:0]   deb_rule;
	logic [STEPS_W-1:0] steps_dec;
	logic               count_done;

	logic in_accept;
	logic advance;

	// Handshakes
	assign advance        = valid_s1 && (!out_valid_q || out_item.ready);
	assign in_accept      = in_item.valid && in_item.ready;
	assign in_item.ready  = !valid_s1 || advance;
	assign cfg.ready      = 1'b1;
	assign out_item.valid = out_valid_q;
	assign out_item.payload = out_q;

	// Shared terms of the stop rules
	always_comb begin
		pos_step = push_q ? (pos_q - 1'b1) : (pos_q + 1'b1);
		opt_sel  = (lmode_q == SM_OPT1_CHECK || lmode_q == SM_OPT1_SEEK) ?
			item_s1.optic1_level : item_s1.optic0_level;
		opt_seen = opt_sel < optic_thresh_q;
		// when pulling, end hit is judged on the position after this step; when pushing, on the end switch
		hit       = push_q ? item_s1.end_switch : (pos_step >= pull_limit_q);
		deb_bound = (lmode_q == SM_END) ? DEB_LIMIT : '0;
		deb_max   = (deb_bound > deb_q) ? deb_bound : deb_q;
		fire_cand = hit && (deb_max >= DEB_LIMIT);
		if (!hit) begin
			deb_rule = '0;
		end else if (fire_cand) begin
			deb_rule = deb_max;
		end else begin
			deb_rule = deb_max + 1'b1;
		end
		steps_dec  = (steps_q != '0) ? (steps_q - 1'b1) : steps_q;
		count_done = (steps_dec == '0);
	end

	// Item update
	always_comb begin
		pos_n   = pos_q;
		steps_n = steps_q;
		deb_n   = deb_q;
		speed_n = speed_q;
		goal_n  = goal_q;
		push_n  = push_q;
		lmode_n = lmode_q;
		optic_n = optic_q;
		run_n   = run_q;
		stop    = 1'b0;
		fired   = 1'b0;

		if (item_kind_t'(item_s1.mode) == ITEM_START) begin
			goal_n  = item_s1.target_speed;
			push_n  = item_s1.push_direction;
			lmode_n = stop_mode_t'(item_s1.stop_mode);
			optic_n = 1'b0;
			if (item_s1.target_speed != '0 && item_s1.step_count != '0) begin
				steps_n = item_s1.step_count;
				speed_n = (item_s1.target_speed > SPEED_CAP) ? SPEED_CAP
					: item_s1.target_speed;
				run_n   = 1'b1;
			end else begin
				run_n   = 1'b0;
			end
		end else if (run_q) begin
			pos_n = pos_step;
			unique case (lmode_q) inside
				SM_END: begin
					deb_n = deb_rule;
					fired = fire_cand;
					stop  = fire_cand;
				end
				SM_OPT1_CHECK, SM_OPT0_CHECK: begin
					optic_n = opt_seen;
					if (!opt_seen) begin
						stop = 1'b1;
					end else begin
						deb_n = deb_rule;
						fired = fire_cand;
						if (!fire_cand) begin
							steps_n = steps_dec;
						end
						stop = fire_cand || count_done;
					end
				end
				SM_OPT0_SEEK, SM_OPT1_SEEK: begin
					optic_n = opt_seen;
					if (opt_seen) begin
						stop = 1'b1;
					end else begin
						deb_n = deb_rule;
						fired = fire_cand;
						stop  = fire_cand;
					end
				end
				SM_FREE: begin
					deb_n = deb_rule;
					fired = fire_cand;
					if (!fire_cand) begin
						steps_n = steps_dec;
					end
					stop = fire_cand || count_done;
				end
				SM_STOP: begin
					stop = 1'b1;
				end
				SM_NONE: begin
					stop = 1'b0;
				end
			endcase
			// firing while pushing marks the home position
			if (fired && push_q) begin
				pos_n = '0;
			end
			// speed ramp, also on the stopping pulse
			if (goal_q > speed_q) begin
				speed_n = speed_q + 1'b1;
			end
			if (stop) begin
				run_n = 1'b0;
			end
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			optic_thresh_q <= OPTIC_THRESH_RESET;
			pull_limit_q   <= PULL_LIMIT_RESET;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg_reg_t'(cfg.payload.index))
				REG_OPTIC_THRESHOLD: optic_thresh_q <= cfg.payload.data[LEVEL_W-1:0];
				REG_PULL_LIMIT:      pull_limit_q   <= cfg.payload.data[POS_W-1:0];
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_s1 <= in_item.payload;
		end
	end

	// Move state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= POS_RESET;
			steps_q <= '0;
			deb_q   <= '0;
			speed_q <= '0;
			goal_q  <= '0;
			push_q  <= 1'b0;
			lmode_q <= SM_NONE;
			optic_q <= 1'b0;
			run_q   <= 1'b0;
		end else if (advance) begin
			pos_q   <= pos_n;
			steps_q <= steps_n;
			deb_q   <= deb_n;
			speed_q <= speed_n;
			goal_q  <= goal_n;
			push_q  <= push_n;
			lmode_q <= lmode_n;
			optic_q <= optic_n;
			run_q   <= run_n;
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_item.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q.moving        <= run_n;
			out_q.stop_now      <= stop;
			out_q.position      <= pos_n;
			out_q.current_speed <= speed_n;
			out_q.optic_ok      <= optic_n;
			out_q.end_hit       <= fired;
		end
	end

endmodule

>>> rtl/core/spp_checker.sv
// Port-level assertions for the stepper pulse positioner, with their bind.
module spp_checker
	import spp_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_payload
);

	// A stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	// A stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_payload))
		else $error("result payload changed while stalled");

	// The pulse that ends a move leaves the motor stopped
	a_stop_clears_moving: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.stop_now |-> !out_payload.moving)
		else $error("stop reported while still moving");

	// An end-rule firing always ends the move
	a_end_hit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload.end_hit |-> out_payload.stop_now)
		else $error("end rule fired without stopping");

endmodule

bind stepper_pulse_positioner spp_checker u_spp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_item.valid),
	.out_ready   (out_item.ready),
	.out_payload (out_item.payload)
);
